/* hw/rtl/fca_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types and constants of the fault cluster aggregator.
// ----------------------------------------------------------------------------
package fca_pkg;

  // table geometry
  localparam int NUM_CLUSTERS = 64;
  localparam int MAX_FAULTS   = 64;
  localparam int FAULT_IDX_W  = (MAX_FAULTS > 1) ? $clog2(MAX_FAULTS) : 1;

  // status code that marks a fault as active
  localparam logic [7:0] STATUS_ACTIVE = 8'd1;

  // command codes
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // outcome codes
  typedef enum logic [1:0] {
    OUT_NONE    = 2'd0,
    OUT_ADDED   = 2'd1,
    OUT_REMOVED = 2'd2,
    OUT_FULL    = 2'd3
  } fca_outcome_e;

  // input request payload
  typedef struct packed {
    logic        cmd;
    logic [5:0]  cluster_index;
    logic [31:0] fault_key;
    logic [7:0]  fault_status;
    logic [2:0]  bit_position;
  } fca_in_t;

  // result payload
  typedef struct packed {
    logic [5:0] cluster_echo;
    logic [7:0] cluster_value;
    logic [1:0] outcome;
  } fca_out_t;

  // search wave handed from cell to cell
  typedef struct packed {
    logic                   active;
    logic                   found;
    logic [FAULT_IDX_W-1:0] hit_idx;
    logic [2:0]             hit_bit;
    logic                   free_any;
    logic [FAULT_IDX_W-1:0] free_idx;
    logic [7:0]             acc;
  } fca_wave_t;

  // entry write command broadcast to all cells
  typedef struct packed {
    logic                   en;
    logic                   insert;
    logic [FAULT_IDX_W-1:0] idx;
    logic [5:0]             cluster;
    logic [31:0]            key;
    logic [2:0]             bit_pos;
  } fca_wr_t;

endpackage

/* hw/rtl/fca_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_cell
// One table entry; checks it against the passing search wave and forwards
// the updated wave to the next cell through its wave register.
// ----------------------------------------------------------------------------
module fca_cell
  import fca_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [FAULT_IDX_W-1:0] idx_i,
  input  fca_in_t                req_i,
  input  fca_wave_t              wave_i,
  output fca_wave_t              wave_o,
  input  fca_wr_t                wr_i
);

  logic                   valid_q;
  logic [5:0]             cluster_q;
  logic [31:0]            key_q;
  logic [2:0]             bit_q;
  fca_wave_t              wave_q, wave_d;
  logic                   same_cl;
  logic                   match;

  // compare the entry with the request being swept
  assign same_cl = valid_q && (cluster_q == req_i.cluster_index);
  assign match   = same_cl && (key_q == req_i.fault_key);

  // fold this entry into the wave
  always_comb begin
    wave_d = wave_i;
    if (match && !wave_i.found) begin
      wave_d.found   = 1'b1;
      wave_d.hit_idx = idx_i;
      wave_d.hit_bit = bit_q;
    end else if (same_cl) begin
      wave_d.acc = wave_i.acc | (8'b1 << bit_q);
    end
    if (!valid_q && !wave_i.free_any) begin
      wave_d.free_any = 1'b1;
      wave_d.free_idx = idx_i;
    end
  end

  // wave stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= '0;
    end else begin
      wave_q <= wave_d;
    end
  end

  assign wave_o = wave_q;

  // entry valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_i.en && (wr_i.idx == idx_i)) begin
      valid_q <= wr_i.insert;
    end
  end

  // entry contents
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.insert && (wr_i.idx == idx_i)) begin
      cluster_q <= wr_i.cluster;
      key_q     <= wr_i.key;
      bit_q     <= wr_i.bit_pos;
    end
  end

endmodule

/* hw/rtl/fault_cluster_aggregator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fault_cluster_aggregator_unit
// Table of active faults grouped into clusters, with per-cluster OR values.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the in channel (valid/ready) either updates fault membership
//   (cmd 0: add the cluster/key pair when the status is active, remove it
//   when cleared) or reads a cluster value (cmd 1). Every request returns
//   exactly one result on the out channel: the cluster index, the cluster
//   value after the request and an outcome code.
//   Each table entry lives in one cell of a row of MAX_FAULTS cells. A search
//   wave enters the first cell after a request is taken and moves one cell
//   per cycle, collecting the match, the lowest free entry and the OR of the
//   cluster's other entries; the entry write is broadcast afterwards.
//   The search wave runs from the launch register through the wave register
//   of every cell; the decision then goes to the pending result register and
//   on to the output register. One request is in flight at a time: a new
//   one is taken only after the previous result is in the output register.
//   Reset empties the table and all cluster values read as zero; no
//   clearing pass is needed. The result sits in an output register; a new
//   request is taken while it waits, and a finished result is held back
//   until the receiver has taken the previous one.
// ----------------------------------------------------------------------------
module fault_cluster_aggregator_unit
  import fca_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  fca_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output fca_out_t out_rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_PUSH
  } state_e;

  state_e    state_q, state_d;
  fca_in_t   req_q, req_d;
  fca_wave_t launch_q, launch_d;
  fca_wr_t   wr_q, wr_d;
  fca_out_t  pend_q, pend_d;
  fca_out_t  out_q, out_d;
  logic      out_valid_q, out_valid_d;

  fca_wave_t wave [MAX_FAULTS+1];
  fca_wave_t wave_end;
  logic      [MAX_FAULTS-1:0] wave_act;

  logic       in_range;
  logic [7:0] hit_mask;
  logic [7:0] new_mask;

  // row of entry cells
  assign wave[0] = launch_q;
  for (genvar i = 0; i < MAX_FAULTS; i++) begin : g_cell
    fca_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (FAULT_IDX_W'(i)),
      .req_i  (req_q),
      .wave_i (wave[i]),
      .wave_o (wave[i+1]),
      .wr_i   (wr_q)
    );
    assign wave_act[i] = wave[i+1].active;
  end
  assign wave_end = wave[MAX_FAULTS];

  // decision helpers
  assign in_range = (32'(req_q.cluster_index) < 32'(NUM_CLUSTERS));
  assign hit_mask = wave_end.found ? (8'b1 << wave_end.hit_bit) : 8'b0;
  assign new_mask = 8'b1 << req_q.bit_position;

  assign in_ready_o = (state_q == S_IDLE);

  // control and decision
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    launch_d    = '0;
    wr_d        = wr_q;
    wr_d.en     = 1'b0;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d           = in_req_i;
          launch_d.active = 1'b1;
          state_d         = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (wave_end.active) begin
          pend_d.cluster_echo  = req_q.cluster_index;
          pend_d.cluster_value = 8'b0;
          pend_d.outcome       = OUT_NONE;
          wr_d.insert          = 1'b0;
          wr_d.idx             = wave_end.hit_idx;
          wr_d.cluster         = req_q.cluster_index;
          wr_d.key             = req_q.fault_key;
          wr_d.bit_pos         = req_q.bit_position;
          if (in_range) begin
            if (req_q.cmd == CMD_READ) begin
              pend_d.cluster_value = wave_end.acc | hit_mask;
            end else if (wave_end.found) begin
              if (req_q.fault_status != STATUS_ACTIVE) begin
                wr_d.en              = 1'b1;
                pend_d.cluster_value = wave_end.acc;
                pend_d.outcome       = OUT_REMOVED;
              end else begin
                pend_d.cluster_value = wave_end.acc | hit_mask;
              end
            end else if (req_q.fault_status == STATUS_ACTIVE) begin
              if (wave_end.free_any) begin
                wr_d.en              = 1'b1;
                wr_d.insert          = 1'b1;
                wr_d.idx             = wave_end.free_idx;
                pend_d.cluster_value = wave_end.acc | new_mask;
                pend_d.outcome       = OUT_ADDED;
              end else begin
                pend_d.cluster_value = wave_end.acc;
                pend_d.outcome       = OUT_FULL;
              end
            end else begin
              pend_d.cluster_value = wave_end.acc;
            end
          end
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launch_q    <= '0;
      wr_q        <= '0;
      out_valid_q <= 1'b0;
      req_q       <= '0;
      pend_q      <= '0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      launch_q    <= launch_d;
      wr_q        <= wr_d;
      out_valid_q <= out_valid_d;
      req_q       <= req_d;
      pend_q      <= pend_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // at most one search wave travels the cell row
  a_single_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({wave_act, launch_q.active}))
    else $error("more than one search wave in the cell row");

  // a wave only reaches the row end during a sweep
  a_wave_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wave_end.active |-> (state_q == S_SWEEP))
    else $error("search wave outside of a sweep");

  // an entry write follows a sweep and lasts one cycle
  a_write_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q.en |-> (state_q == S_PUSH) && $past(wave_end.active))
    else $error("entry write not right after a sweep");

  // an entry write always goes with an add or remove outcome
  a_write_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q.en |-> (pend_q.outcome == OUT_ADDED || pend_q.outcome == OUT_REMOVED))
    else $error("entry write without add or remove outcome");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fault cluster aggregator. A local fault table
// predicts every result at request acceptance; results are compared field by
// field in arrival order. Covers field extremes, add/remove/keep paths, a full
// table with dropped inserts, long output backpressure and random traffic
// with sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
  import fca_pkg::*;

  localparam int HALF_PERIOD    = 2;
  localparam int RESET_CYCLES   = 9;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int RESULT_LATENCY = MAX_FAULTS + 3;
  localparam int PRINT_CAP      = 40;
  localparam int KEY_POOL_N     = 12;
  localparam int CLUSTER_POOL_N = 6;

  // clock, reset and block ports
  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  fca_in_t  in_req_i    = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  fca_out_t out_rsp_o;

  // local copy of the fault table
  logic       fault_live    [MAX_FAULTS];
  logic [5:0] fault_cluster [MAX_FAULTS];
  logic [31:0] fault_key    [MAX_FAULTS];
  logic [2:0] fault_bit     [MAX_FAULTS];
  logic [7:0] cluster_level [NUM_CLUSTERS];

  // results still owed by the block, oldest first
  fca_out_t pending_results[$];
  fca_out_t expected_rsp;

  int mismatch_count = 0;
  int cycle_count    = 0;
  int tx_idle_pct    = 28;
  int rx_idle_pct    = 63;
  int rx_hold_req    = 0;
  int rx_hold_left   = 0;

  fault_cluster_aggregator_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // clock
  always #(HALF_PERIOD) clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // receiver readiness, with an optional long hold-off
  always @(posedge clk_i) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("mismatch on %s: got %0d, expected %0d (cycle %0d)",
               what, got, want, cycle_count);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unrequested result, cluster_echo", int'(out_rsp_o.cluster_echo), -1);
      end else begin
        expected_rsp = pending_results.pop_front();
        if (out_rsp_o.cluster_echo !== expected_rsp.cluster_echo)
          report_mismatch("cluster_echo", int'(out_rsp_o.cluster_echo),
                          int'(expected_rsp.cluster_echo));
        if (out_rsp_o.cluster_value !== expected_rsp.cluster_value)
          report_mismatch("cluster_value", int'(out_rsp_o.cluster_value),
                          int'(expected_rsp.cluster_value));
        if (out_rsp_o.outcome !== expected_rsp.outcome)
          report_mismatch("outcome", int'(out_rsp_o.outcome), int'(expected_rsp.outcome));
      end
    end
  end

  // table update and expected result for one accepted request
  function automatic fca_out_t predict_cluster_result(input fca_in_t req);
    fca_out_t   rsp;
    int         hit;
    int         slot;
    logic [7:0] acc;
    rsp              = '0;
    rsp.cluster_echo = req.cluster_index;
    rsp.outcome      = OUT_NONE;
    hit              = -1;
    slot             = -1;
    if (int'(req.cluster_index) < NUM_CLUSTERS) begin
      if (req.cmd == CMD_UPDATE) begin
        // look up the cluster/key pair
        for (int i = 0; i < MAX_FAULTS; i++) begin
          if (hit < 0 && fault_live[i] && fault_cluster[i] == req.cluster_index &&
              fault_key[i] == req.fault_key) begin
            hit = i;
          end
        end
        if (hit < 0) begin
          if (req.fault_status == STATUS_ACTIVE) begin
            // lowest free entry takes the new fault
            for (int i = 0; i < MAX_FAULTS; i++) begin
              if (slot < 0 && !fault_live[i]) slot = i;
            end
            if (slot >= 0) begin
              fault_live[slot]    = 1'b1;
              fault_cluster[slot] = req.cluster_index;
              fault_key[slot]     = req.fault_key;
              fault_bit[slot]     = req.bit_position;
              rsp.outcome         = OUT_ADDED;
            end else begin
              rsp.outcome = OUT_FULL;
            end
          end
        end else if (req.fault_status != STATUS_ACTIVE) begin
          fault_live[hit] = 1'b0;
          rsp.outcome     = OUT_REMOVED;
        end
        // rebuild the cluster value
        acc = '0;
        for (int i = 0; i < MAX_FAULTS; i++) begin
          if (fault_live[i] && fault_cluster[i] == req.cluster_index) acc[fault_bit[i]] = 1'b1;
        end
        cluster_level[req.cluster_index] = acc;
      end
      rsp.cluster_value = cluster_level[req.cluster_index];
    end
    return rsp;
  endfunction

  function automatic fca_in_t make_request(input logic cmd, input logic [5:0] cluster,
                                           input logic [31:0] key, input logic [7:0] status,
                                           input logic [2:0] bit_pos);
    fca_in_t req;
    req.cmd           = cmd;
    req.cluster_index = cluster;
    req.fault_key     = key;
    req.fault_status  = status;
    req.bit_position  = bit_pos;
    return req;
  endfunction

  function automatic logic [7:0] cleared_status();
    logic [7:0] s;
    s = 8'($urandom_range(255));
    if (s == STATUS_ACTIVE) s = 8'h00;
    return s;
  endfunction

  function automatic int live_fault_count();
    int n;
    n = 0;
    for (int i = 0; i < MAX_FAULTS; i++) if (fault_live[i]) n++;
    return n;
  endfunction

  // random live entry, or -1 when the table is empty
  function automatic int pick_live_slot();
    int start;
    int idx;
    start = $urandom_range(MAX_FAULTS - 1);
    for (int i = 0; i < MAX_FAULTS; i++) begin
      idx = (start + i) % MAX_FAULTS;
      if (fault_live[idx]) return idx;
    end
    return -1;
  endfunction

  // offer one request, with random idle cycles ahead of it
  task automatic send_request(input fca_in_t req);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(predict_cluster_result(req));
  endtask

  // stop offering and wait for every owed result
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // field extremes and each update path
  task automatic test_directed_cases();
    // reads right after reset, at both ends of the cluster range
    send_request(make_request(CMD_READ, 6'd0, $urandom, 8'($urandom), 3'($urandom)));
    send_request(make_request(CMD_READ, 6'd63, 32'hFFFF_FFFF, 8'hFF, 3'd7));
    // first inserts at the field extremes
    send_request(make_request(CMD_UPDATE, 6'd0, 32'h0, STATUS_ACTIVE, 3'd0));
    send_request(make_request(CMD_UPDATE, 6'd63, 32'hFFFF_FFFF, STATUS_ACTIVE, 3'd7));
    // active fault already present keeps its stored bit
    send_request(make_request(CMD_UPDATE, 6'd63, 32'hFFFF_FFFF, STATUS_ACTIVE, 3'd3));
    // same key in another cluster is a separate fault
    send_request(make_request(CMD_UPDATE, 6'd63, 32'h0, STATUS_ACTIVE, 3'd3));
    // read with an active status and a new key must not insert
    send_request(make_request(CMD_READ, 6'd63, 32'h1234_5678, STATUS_ACTIVE, 3'd1));
    // removal, clear of an absent fault, removal with another cleared code
    send_request(make_request(CMD_UPDATE, 6'd63, 32'hFFFF_FFFF, 8'h00, 3'd0));
    send_request(make_request(CMD_UPDATE, 6'd63, 32'hFFFF_FFFF, 8'hFF, 3'd7));
    send_request(make_request(CMD_UPDATE, 6'd63, 32'h0, 8'h02, 3'd0));
    // every bit position in one cluster
    for (int b = 0; b < 8; b++) begin
      send_request(make_request(CMD_UPDATE, 6'd21, 32'hA5A5_0000 | b, STATUS_ACTIVE, 3'(b)));
    end
    // two faults share a bit, one leaves and the bit stays set
    send_request(make_request(CMD_UPDATE, 6'd21, 32'h5A5A_5A5A, STATUS_ACTIVE, 3'd4));
    send_request(make_request(CMD_UPDATE, 6'd21, 32'hA5A5_0004, 8'h80, 3'd0));
    send_request(make_request(CMD_UPDATE, 6'd0, 32'h0, 8'hFE, 3'd5));
  endtask

  // fill the table, drop inserts, free and refill entries, then empty it
  task automatic test_table_full();
    int slot;
    // fresh faults until every entry is taken
    while (live_fault_count() < MAX_FAULTS) begin
      send_request(make_request(CMD_UPDATE, 6'($urandom_range(63)), $urandom, STATUS_ACTIVE,
                                3'($urandom_range(7))));
    end
    // inserts into the full table are dropped
    repeat (6) begin
      send_request(make_request(CMD_UPDATE, 6'($urandom_range(63)), $urandom, STATUS_ACTIVE,
                                3'($urandom_range(7))));
    end
    // present fault reported active again while full
    slot = pick_live_slot();
    send_request(make_request(CMD_UPDATE, fault_cluster[slot], fault_key[slot], STATUS_ACTIVE,
                              3'($urandom_range(7))));
    // free a few entries and refill them, one insert too many
    repeat (3) begin
      slot = pick_live_slot();
      send_request(make_request(CMD_UPDATE, fault_cluster[slot], fault_key[slot],
                                cleared_status(), 3'($urandom_range(7))));
    end
    repeat (4) begin
      send_request(make_request(CMD_UPDATE, 6'($urandom_range(63)), $urandom, STATUS_ACTIVE,
                                3'($urandom_range(7))));
    end
    // empty the table
    for (int i = 0; i < MAX_FAULTS; i++) begin
      if (fault_live[i]) begin
        send_request(make_request(CMD_UPDATE, fault_cluster[i], fault_key[i], cleared_status(),
                                  3'($urandom_range(7))));
      end
    end
  endtask

  // long receiver hold-off while requests keep coming, then a full drain
  task automatic test_output_backpressure();
    rx_hold_req = 400;
    repeat (10) begin
      send_request(make_request(1'($urandom_range(1)), 6'($urandom_range(7)),
                                $urandom_range(3),
                                $urandom_range(1) ? STATUS_ACTIVE : cleared_status(),
                                3'($urandom_range(7))));
    end
    wait_for_drain();
  endtask

  // random traffic on a small set of clusters and keys so pairs recur
  task automatic test_random_traffic(input int count);
    logic [31:0] key_pool     [KEY_POOL_N];
    logic [5:0]  cluster_pool [CLUSTER_POOL_N];
    fca_in_t     req;
    for (int i = 0; i < KEY_POOL_N; i++) key_pool[i] = $urandom;
    for (int i = 0; i < CLUSTER_POOL_N; i++) cluster_pool[i] = 6'($urandom_range(63));
    repeat (count) begin
      req.cmd = ($urandom_range(99) < 15) ? CMD_READ : CMD_UPDATE;
      req.cluster_index = ($urandom_range(99) < 85) ?
                          cluster_pool[$urandom_range(CLUSTER_POOL_N - 1)] :
                          6'($urandom_range(63));
      req.fault_key = ($urandom_range(99) < 85) ?
                      key_pool[$urandom_range(KEY_POOL_N - 1)] : $urandom;
      req.fault_status = ($urandom_range(99) < 55) ? STATUS_ACTIVE : 8'($urandom_range(255));
      req.bit_position = 3'($urandom_range(7));
      send_request(req);
    end
  endtask

  // test sequence
  initial begin
    // local table starts empty, as the block does after reset
    for (int i = 0; i < MAX_FAULTS; i++) fault_live[i] = 1'b0;
    for (int c = 0; c < NUM_CLUSTERS; c++) cluster_level[c] = 8'h00;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(28, 63);
    test_directed_cases();
    test_table_full();
    test_output_backpressure();
    test_random_traffic(100);

    set_idling(63, 28);
    test_random_traffic(100);
    wait_for_drain();

    set_idling(0, 0);
    test_random_traffic(100);

    wait_for_drain();
    repeat (RESULT_LATENCY) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
